>>> rtl/qfrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qfrm_pkg;
    localparam int unsigned DATA_WIDTH_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF  = 14;

    // Branch codes: trace formula or the largest diagonal entry.
    localparam logic [1:0] BR_X     = 2'd0;
    localparam logic [1:0] BR_Y     = 2'd1;
    localparam logic [1:0] BR_Z     = 2'd2;
    localparam logic [1:0] BR_TRACE = 2'd3;
endpackage
`default_nettype wire

>>> rtl/quaternion_from_rotation_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix to quaternion converter (Shepperd's method), fixed point.
// Slave channel: s_axis_* carries one request: the nine matrix entries,
//   row-major, each DATA_WIDTH bits signed with FRAC_BITS fraction bits.
// Master channel: m_axis_* returns quat x, y, z, w (saturated) and, in
//   tuser, a fault flag set for a negative radicand or a zero divisor.
// Pipeline: 1 stage forms the trace and picks the branch, 1 stage forms the
//   radicand and numerators, RW/2 stages of square root, one stage sets up
//   the divisor, NW divide stages, and the output register after the
//   saturation logic, with RW = ((DATA_WIDTH+FRAC_BITS+3)/2)*2 and
//   NW = DATA_WIDTH+FRAC_BITS+2. The square root and divider arrays
//   resolve one bit per stage.
// Throughput: one request per cycle. The whole pipe advances on a global
//   enable that drops only when the output register is full and the
//   receiver holds tready low; every stage holds its contents while it stalls.
// Reset clears every valid bit; payload registers are not reset.
module quaternion_from_rotation_matrix
    import qfrm_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // row0_col0, row0_col1, ... row2_col2 from bit 0 up
    input  wire logic [((9 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w from bit 0 up
    output logic [((4 * DATA_WIDTH + 7) / 8) * 8 - 1:0]      m_axis_tdata,
    // fault
    output logic                         m_axis_tuser
);
    localparam int unsigned DW    = DATA_WIDTH;
    localparam int unsigned TDI_W = ((9 * DATA_WIDTH + 7) / 8) * 8;
    localparam int unsigned TDO_W = ((4 * DATA_WIDTH + 7) / 8) * 8;
    // Sums of up to three entries plus one: DW+2 bits signed.
    localparam int unsigned AW    = DW + 2;
    // Radicand shifted left by FRAC_BITS, even width for the root.
    localparam int unsigned RW    = ((AW + FRAC_BITS + 1) / 2) * 2;
    localparam int unsigned RTW   = RW / 2;
    localparam int unsigned SDW   = RTW + 1;
    // Numerator magnitude (DW+1 bits) shifted by FRAC_BITS, plus rounding.
    localparam int unsigned NW    = DW + 1 + FRAC_BITS + 1;
    // Side data for the root stage: 3 signed numerators, branch, fault.
    localparam int unsigned NMW   = DW + 1;
    localparam int unsigned SQS   = 3 * NMW + 2 + 1;
    // Side data for the divider: sign, branch, fault, half-root.
    localparam int unsigned DVS   = 1 + 2 + 1 + RTW;

    logic w_en;
    logic r_ov;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage 1: capture entries, form the trace, pick the branch.
    logic signed [DW-1:0] w_m [9];
    for (genvar k = 0; k < 9; k++) begin : g_in
        assign w_m[k] = s_axis_tdata[k*DW +: DW];
    end

    logic signed [DW-1:0] r1_m [9];
    logic [1:0]           r1_br;
    logic                 r1_v;
    logic signed [AW-1:0] n1_tr;
    logic [1:0]           n1_br;

    always_comb begin
        n1_tr = AW'(w_m[0]) + AW'(w_m[4]) + AW'(w_m[8]);
        if (n1_tr > 0) begin
            n1_br = BR_TRACE;
        end else if (w_m[8] > w_m[0] && w_m[8] > w_m[4]) begin
            n1_br = BR_Z;
        end else if (w_m[4] > w_m[0]) begin
            n1_br = BR_Y;
        end else begin
            n1_br = BR_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_m  <= w_m;
            r1_br <= n1_br;
        end
    end

    // Stage 2: radicand and the three numerators for the branch.
    logic signed [AW-1:0]  n2_rad;
    logic signed [NMW-1:0] n2_a, n2_b, n2_c;
    logic signed [AW-1:0]  w_one;
    logic signed [AW-1:0]  w_d0, w_d1, w_d2;
    logic signed [NMW-1:0] w_e01, w_e02, w_e12;
    logic signed [NMW-1:0] w_s01, w_s02, w_s12;

    always_comb begin
        w_one  = AW'(1) << FRAC_BITS;
        w_d0   = AW'(r1_m[0]);
        w_d1   = AW'(r1_m[4]);
        w_d2   = AW'(r1_m[8]);
        w_e12  = NMW'(r1_m[5]) - NMW'(r1_m[7]);
        w_e02  = NMW'(r1_m[6]) - NMW'(r1_m[2]);
        w_e01  = NMW'(r1_m[1]) - NMW'(r1_m[3]);
        w_s01  = NMW'(r1_m[1]) + NMW'(r1_m[3]);
        w_s02  = NMW'(r1_m[2]) + NMW'(r1_m[6]);
        w_s12  = NMW'(r1_m[5]) + NMW'(r1_m[7]);
        case (r1_br)
            BR_TRACE: begin
                n2_rad = w_one + w_d0 + w_d1 + w_d2;
                n2_a = w_e12; n2_b = w_e02; n2_c = w_e01;
            end
            BR_X: begin
                n2_rad = w_one + w_d0 - w_d1 - w_d2;
                n2_a = w_s01; n2_b = w_s02; n2_c = w_e12;
            end
            BR_Y: begin
                n2_rad = w_one + w_d1 - w_d0 - w_d2;
                n2_a = w_s01; n2_b = w_s12; n2_c = w_e02;
            end
            default: begin
                n2_rad = w_one + w_d2 - w_d0 - w_d1;
                n2_a = w_s02; n2_b = w_s12; n2_c = w_e01;
            end
        endcase
    end

    logic [RW-1:0]  r2_rad;
    logic [SQS-1:0] r2_side;
    logic           r2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end
    // Clamp a negative radicand to zero and flag it.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rad  <= n2_rad[AW-1] ? '0
                       : (RW'(n2_rad[AW-2:0]) << FRAC_BITS);
            r2_side <= {n2_rad[AW-1], r1_br, n2_c, n2_b, n2_a};
        end
    end

    // Square root array.
    logic           w3_v;
    logic [RTW-1:0] w3_rt;
    logic [SQS-1:0] w3_side;

    qfrm_sqrt #(.RW(RW), .SW(SQS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_rad   (r2_rad),
        .i_side  (r2_side),
        .o_valid (w3_v),
        .o_root  (w3_rt),
        .o_side  (w3_side)
    );

    // Stage 4: fan the three numerators out to three dividers.
    logic signed [NMW-1:0] w3_n [3];
    logic [1:0]            w3_br;
    logic                  w3_flt;
    logic [RTW:0]          w3_half_sum;
    logic [RTW-1:0]        w3_half;
    logic [SDW-1:0]        w3_s;

    always_comb begin
        w3_n[0]     = w3_side[0*NMW +: NMW];
        w3_n[1]     = w3_side[1*NMW +: NMW];
        w3_n[2]     = w3_side[2*NMW +: NMW];
        w3_br       = w3_side[3*NMW +: 2];
        w3_flt      = w3_side[SQS-1] || (w3_rt == '0);
        w3_half_sum = {1'b0, w3_rt} + (RTW+1)'(1);
        w3_half     = w3_half_sum[RTW:1];
        w3_s        = (w3_rt == '0) ? SDW'(1) : {w3_rt, 1'b0};
    end

    logic [NW-1:0]  r4_num [3];
    logic [SDW-1:0] r4_s;
    logic [DVS-1:0] r4_side [3];
    logic           r4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= w3_v;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_num
        logic [NMW-1:0] n_mag;
        assign n_mag = w3_n[k][NMW-1] ? NMW'(-w3_n[k]) : NMW'(w3_n[k]);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                // Add half the divisor for round-to-nearest.
                r4_num[k]  <= (NW'(n_mag) << FRAC_BITS) + NW'(w3_s >> 1);
                r4_side[k] <= {w3_half, w3_flt, w3_br, w3_n[k][NMW-1]};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s <= w3_s;
        end
    end

    // Three dividers in lockstep.
    logic           w5_v [3];
    logic [NW-1:0]  w5_q [3];
    logic [DVS-1:0] w5_side [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        qfrm_div #(.NW(NW), .DW(SDW), .SW(DVS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r4_v),
            .i_num   (r4_num[k]),
            .i_den   (r4_s),
            .i_side  (r4_side[k]),
            .o_valid (w5_v[k]),
            .o_quo   (w5_q[k]),
            .o_side  (w5_side[k])
        );
    end

    // Final stage: saturate, place components, hold in the output register.
    function automatic logic [DATA_WIDTH-1:0] sat_mag(
        input logic neg, input logic [NW-1:0] mag);
        logic [NW:0] lim;
        lim = (NW+1)'(1) << (DATA_WIDTH - 1);
        if (neg) begin
            sat_mag = ({1'b0, mag} >= lim) ? lim[DATA_WIDTH-1:0]
                      : DATA_WIDTH'(-mag);
        end else begin
            sat_mag = ({1'b0, mag} >= lim) ? DATA_WIDTH'(lim - 1)
                      : mag[DATA_WIDTH-1:0];
        end
    endfunction

    logic [DW-1:0] w5_r [3];
    logic [DW-1:0] w5_h;
    logic [1:0]    w5_br;
    logic          w5_flt;
    logic [DW-1:0] n_qx, n_qy, n_qz, n_qw;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w5_r[k] = sat_mag(w5_side[k][0], w5_q[k]);
        end
        w5_br  = w5_side[0][2:1];
        w5_flt = w5_side[0][3];
        w5_h   = sat_mag(1'b0, NW'(w5_side[0][DVS-1 -: RTW]));
        case (w5_br)
            BR_TRACE: begin
                n_qx = w5_r[0]; n_qy = w5_r[1]; n_qz = w5_r[2]; n_qw = w5_h;
            end
            BR_X: begin
                n_qx = w5_h; n_qy = w5_r[0]; n_qz = w5_r[1]; n_qw = w5_r[2];
            end
            BR_Y: begin
                n_qx = w5_r[0]; n_qy = w5_h; n_qz = w5_r[1]; n_qw = w5_r[2];
            end
            default: begin
                n_qx = w5_r[0]; n_qy = w5_r[1]; n_qz = w5_h; n_qw = w5_r[2];
            end
        endcase
    end

    logic [4*DW-1:0] r_od;
    logic            r_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w5_v[0] && w5_v[1] && w5_v[2];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od <= {n_qw, n_qz, n_qy, n_qx};
            r_of <= w5_flt;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = TDO_W'(r_od);
    assign m_axis_tuser  = r_of;
endmodule
`default_nettype wire

>>> rtl/qfrm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
// Side data of SW bits rides along with each operand.
module qfrm_sqrt #(
    parameter int unsigned RW = 34,
    parameter int unsigned SW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [RW-1:0]   i_rad,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [RW/2-1:0]      o_root,
    output logic [SW-1:0]        o_side
);
    localparam int unsigned NB = RW / 2;

    logic [RW-1:0]  r_rem  [1:NB];
    logic [NB-1:0]  r_root [1:NB];
    logic [SW-1:0]  r_side [1:NB];
    logic [NB:1]    r_vld;

    for (genvar g = 0; g < NB; g++) begin : g_stage
        localparam int unsigned SH = 2 * (NB - 1 - g);
        logic [RW-1:0] w_rem;
        logic [NB-1:0] w_root;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [RW+1:0] n_trial;
        logic [RW+1:0] n_cand;
        logic          n_ok;
        if (g == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[g];
            assign w_root = r_root[g];
            assign w_side = r_side[g];
            assign w_vld  = r_vld[g];
        end
        always_comb begin
            n_cand  = ({2'b0, w_root} << (SH + 2)) | ((RW+2)'(1) << SH);
            n_ok    = {2'b0, w_rem} >= n_cand;
            n_trial = {2'b0, w_rem} - n_cand;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= w_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_ok ? n_trial[RW-1:0] : w_rem;
                r_root[g+1] <= {w_root[NB-2:0], n_ok};
                r_side[g+1] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[NB];
    assign o_root  = r_root[NB];
    assign o_side  = r_side[NB];
endmodule
`default_nettype wire

>>> rtl/qfrm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: unsigned quotient, one bit per stage.
// Side data of SW bits travels with the operands.
module qfrm_div #(
    parameter int unsigned NW = 36,
    parameter int unsigned DW = 18,
    parameter int unsigned SW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [SW-1:0]  i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_quo,
    output logic [SW-1:0]       o_side
);
    logic [DW:0]    r_rem  [1:NW];
    logic [NW-1:0]  r_num  [1:NW];
    logic [DW-1:0]  r_den  [1:NW];
    logic [SW-1:0]  r_side [1:NW];
    logic [NW:1]    r_vld;

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [DW:0]   w_rem;
        logic [NW-1:0] w_num;
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [DW+1:0] n_sh;
        logic          n_ok;
        if (g == 0) begin : g_first
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[g];
            assign w_num  = r_num[g];
            assign w_den  = r_den[g];
            assign w_side = r_side[g];
            assign w_vld  = r_vld[g];
        end
        always_comb begin
            n_sh = {w_rem, w_num[NW-1]};
            n_ok = n_sh >= {2'b0, w_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= w_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_ok ? (DW+1)'(n_sh - {2'b0, w_den}) : n_sh[DW:0];
                r_num[g+1]  <= {w_num[NW-2:0], n_ok};
                r_den[g+1]  <= w_den;
                r_side[g+1] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_num[NW];
    assign o_side  = r_side[NW];
endmodule
`default_nettype wire

>>> rtl/qfrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module qfrm_checker #(
    parameter int unsigned TDO_W = 64
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [TDO_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tuser
);
    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");
    // Accept input whenever the output is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    // Stall reaches the input side.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during stall");
    // No output straight out of reset.
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind quaternion_from_rotation_matrix qfrm_checker #(.TDO_W(TDO_W)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> verif/quaternion_from_rotation_matrix_tb.sv
`timescale 1ns / 1ps
module quaternion_from_rotation_matrix_tb;
    import qfrm_pkg::*;

    localparam int DW    = 16;
    localparam int FB    = 14;
    localparam int TDI_W = 9 * DW;
    localparam int TDO_W = 4 * DW;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [DW-1:0] quat_w;
        logic [DW-1:0] quat_z;
        logic [DW-1:0] quat_y;
        logic [DW-1:0] quat_x;
        logic          fault;
    } quat_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [TDI_W-1:0] s_axis_tdata;   // row0_col0 .. row2_col2 from bit 0 up
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [TDO_W-1:0] m_axis_tdata;   // quat_x, quat_y, quat_z, quat_w from bit 0 up
    logic             m_axis_tuser;   // fault

    int error_count = 0;

    quaternion_from_rotation_matrix #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Saturate a sign and magnitude into the signed output range.
    function automatic logic [DW-1:0] saturate(input bit neg, input longint unsigned mag);
        longint v;
        if (neg) v = (mag >= (64'd1 << (DW-1))) ? -(longint'(1) << (DW-1)) : -longint'(mag);
        else     v = (mag > ((64'd1 << (DW-1)) - 1)) ? ((longint'(1) << (DW-1)) - 1)
                                                     : longint'(mag);
        return v[DW-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned root_of(input longint t);
        if (t <= 0) return 0;
        return int_sqrt(longint'(t) << FB);
    endfunction

    // n * 2^FB / s rounded half away from zero; zero divisor counts as one LSB.
    function automatic logic [DW-1:0] quotient(input longint n, input longint unsigned s);
        bit neg;
        longint unsigned mag;
        neg = n < 0;
        mag = neg ? longint'(-n) : longint'(n);
        if (s == 0) s = 1;
        return saturate(neg, ((mag << FB) + (s >> 1)) / s);
    endfunction

    function automatic logic [DW-1:0] half_up(input longint unsigned r);
        return saturate(1'b0, (r + 1) >> 1);
    endfunction

    function automatic quat_t convert_matrix(input logic [TDI_W-1:0] data);
        longint m [3][3];
        longint diag, rad;
        longint unsigned rt, s;
        logic [1:0] branch;
        quat_t q;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = longint'($signed(data[(r*3+c)*DW +: DW]));
        q = '0;
        diag = m[0][0] + m[1][1] + m[2][2];
        if (diag > 0) begin
            rt = root_of(diag + (longint'(1) << FB));
            s  = rt << 1;
            q.quat_x = quotient(m[1][2] - m[2][1], s);
            q.quat_y = quotient(m[2][0] - m[0][2], s);
            q.quat_z = quotient(m[0][1] - m[1][0], s);
            q.quat_w = half_up(rt);
        end else begin
            branch = BR_X;
            if (m[1][1] > m[0][0]) branch = BR_Y;
            if (m[2][2] > ((branch == BR_Y) ? m[1][1] : m[0][0])) branch = BR_Z;
            case (branch)
                BR_X:    rad = (longint'(1) << FB) + m[0][0] - m[1][1] - m[2][2];
                BR_Y:    rad = (longint'(1) << FB) + m[1][1] - m[0][0] - m[2][2];
                default: rad = (longint'(1) << FB) + m[2][2] - m[0][0] - m[1][1];
            endcase
            if (rad < 0) begin
                q.fault = 1'b1;
                rad = 0;
            end
            rt = root_of(rad);
            s  = rt << 1;
            if (s == 0) q.fault = 1'b1;
            case (branch)
                BR_X: begin
                    q.quat_x = half_up(rt);
                    q.quat_y = quotient(m[0][1] + m[1][0], s);
                    q.quat_z = quotient(m[0][2] + m[2][0], s);
                    q.quat_w = quotient(m[1][2] - m[2][1], s);
                end
                BR_Y: begin
                    q.quat_x = quotient(m[0][1] + m[1][0], s);
                    q.quat_y = half_up(rt);
                    q.quat_z = quotient(m[1][2] + m[2][1], s);
                    q.quat_w = quotient(m[2][0] - m[0][2], s);
                end
                default: begin
                    q.quat_x = quotient(m[0][2] + m[2][0], s);
                    q.quat_y = quotient(m[1][2] + m[2][1], s);
                    q.quat_z = half_up(rt);
                    q.quat_w = quotient(m[0][1] - m[1][0], s);
                end
            endcase
        end
        return q;
    endfunction

    class quat_scoreboard;
        quat_t pending_quats[$];

        function void note_request(input logic [TDI_W-1:0] data);
            pending_quats.push_back(convert_matrix(data));
        endfunction

        task check_result(input logic [TDO_W-1:0] data, input logic fault);
            quat_t want;
            if (pending_quats.size() == 0) begin
                report_mismatch("unexpected result", data[DW-1:0], '0);
            end else begin
                want = pending_quats.pop_front();
                if (data[0*DW +: DW] !== want.quat_x)
                    report_mismatch("quat_x", data[0*DW +: DW], want.quat_x);
                if (data[1*DW +: DW] !== want.quat_y)
                    report_mismatch("quat_y", data[1*DW +: DW], want.quat_y);
                if (data[2*DW +: DW] !== want.quat_z)
                    report_mismatch("quat_z", data[2*DW +: DW], want.quat_z);
                if (data[3*DW +: DW] !== want.quat_w)
                    report_mismatch("quat_w", data[3*DW +: DW], want.quat_w);
                if (fault !== want.fault)
                    report_mismatch("fault", DW'(fault), DW'(want.fault));
            end
        endtask
    endclass

    quat_scoreboard sb = new();

    // Idle percentages per phase; the receiver side follows the same phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample both handshakes at the edge; scoreboard sees inputs in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps going.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: nothing accepted for too long ends the run.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_entry();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h4000;  // +1.0
            3:       return 16'hc000;  // -1.0
            4:       return 16'($urandom_range(32768) - 16384);  // plausible range
            default: return 16'($urandom);
        endcase
    endfunction

    // Build a rotation-like matrix from a random quaternion, then perturb it.
    function automatic logic [TDI_W-1:0] rotation_like();
        real x, y, z, w, n;
        real m [9];
        logic [TDI_W-1:0] d;
        x = real'($urandom_range(2000)) - 1000.0;
        y = real'($urandom_range(2000)) - 1000.0;
        z = real'($urandom_range(2000)) - 1000.0;
        w = real'($urandom_range(2000)) - 1000.0;
        n = $sqrt(x*x + y*y + z*z + w*w);
        if (n == 0.0) begin
            w = 1.0;
            n = 1.0;
        end
        x /= n; y /= n; z /= n; w /= n;
        m[0] = 1 - 2*(y*y + z*z); m[1] = 2*(x*y + z*w);     m[2] = 2*(x*z - y*w);
        m[3] = 2*(x*y - z*w);     m[4] = 1 - 2*(x*x + z*z); m[5] = 2*(y*z + x*w);
        m[6] = 2*(x*z + y*w);     m[7] = 2*(y*z - x*w);     m[8] = 1 - 2*(x*x + y*y);
        for (int i = 0; i < 9; i++)
            d[i*DW +: DW] = 16'($rtoi(m[i] * 16384.0) + int'($urandom_range(8)) - 4);
        return d;
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_request(input logic [TDI_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_matrix(input logic [DW-1:0] e [9]);
        logic [TDI_W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*DW +: DW] = e[i];
        send_request(d);
    endtask

    task automatic run_random(input int count);
        logic [TDI_W-1:0] d;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 70) d = rotation_like();
            else for (int i = 0; i < 9; i++) d[i*DW +: DW] = rand_entry();
            send_request(d);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, half turns for each branch, ties, extremes.
        send_matrix('{16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'h4000});
        send_matrix('{16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'hc000});
        send_matrix('{16'hc000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'hc000});
        send_matrix('{16'hc000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'h4000});
        send_matrix('{0, 16'h4000, 0, 16'h4000, 0, 0, 0, 0, 0});       // zero trace, tie
        send_matrix('{16'hc000, 16'h1000, 0, 0, 16'hc000, 0, 0, 0, 16'hc000}); // diagonal tie, x branch
        send_matrix('{16'he000, 16'h1234, 16'h0, 16'h0, 16'he000, 0, 0, 0, 16'he000});
        send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_matrix('{16'hc000, 16'h2000, 16'h0, 0, 16'hc000, 0, 0, 0, 16'h4000}); // z branch
        send_matrix('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_matrix('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_matrix('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        send_matrix('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8001,
                      16'h8000, 16'h7fff, 16'h8000, 16'h8001});
        send_matrix('{16'h0001, 16'h7fff, 16'h8000, 16'h8000, 16'hffff,
                      16'h7fff, 16'h7fff, 16'h8000, 16'h0000});
        send_matrix('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff, 16'hffff});

        // Phases: free flow, sender gaps, receiver stalls, both.
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(400);
        send_idle_pct = 50; recv_stall_pct = 0;  run_random(300);
        send_idle_pct = 0;  recv_stall_pct = 50; run_random(300);

        // Hold the receiver off long enough for the pipe to fill and stall input.
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            run_random(200);
        join

        send_idle_pct = 11; recv_stall_pct = 11; run_random(400);
        s_axis_tvalid <= 1'b0;

        wait (sb.pending_quats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
